FILE: hw/rtl/wildcard_pattern_matcher_top_defines.svh
// Assertion macros shared by the wildcard pattern matcher RTL.
// No dependencies; included by wpm_back, the module that carries assertions.
`ifndef WILDCARD_PATTERN_MATCHER_TOP_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WPM_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WPM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/wpm_pkg.sv
// Types, character codes and the folding function of the wildcard pattern matcher.
// No dependencies; imported by wpm_front, wpm_back and the top level.
package wpm_pkg;

   localparam logic [7:0] STAR_CHAR = 8'h2A;
   localparam logic [7:0] ANY_CHAR  = 8'h3F;
   localparam logic [7:0] ESC_CHAR  = 8'h5C;
   localparam logic [7:0] END_CHAR  = 8'h00;
   localparam logic [7:0] HIGH_KEEP = 8'h80;
   localparam logic [7:0] UPPER_LO  = 8'h41;
   localparam logic [7:0] UPPER_HI  = 8'h5A;
   localparam logic [7:0] CASE_BIT  = 8'h20;

   localparam logic OP_PATTERN_WRITE = 1'b0;
   localparam logic OP_STRING_BYTE   = 1'b1;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // One classified word as it travels from front to back
   typedef struct packed {
      logic       is_string;
      logic       is_end;
      logic [5:0] index;
      logic [7:0] data;
   } wpm_item_type;

   // Map 128 to itself, strip bit 7 of every other byte, then fold A-Z to a-z.
   function automatic logic [7:0] fold_byte(logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b != HIGH_KEEP) begin
         r = {1'b0, b[6:0]};
         if ((r >= UPPER_LO) && (r <= UPPER_HI)) begin
            r = r | CASE_BIT;
         end
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/wpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the pattern store of the matcher.
module wpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/wpm_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
// Depends on wpm_pkg.
module wpm_front import wpm_pkg::*; #(
   parameter int PATTERN_LEN = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  logic         req_opcode,
   input  logic [5:0]   req_pattern_index,
   input  logic [7:0]   req_byte_value,
   output logic         q_empty,
   output wpm_item_type q_item,
   input  logic         q_pop
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   wpm_item_type       slot_ff [QUEUE_DEPTH];
   logic [PTRW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               accept;
   logic               keep;
   wpm_item_type       item;

   assign req_full = (count_ff == CW'(QUEUE_DEPTH));
   assign q_empty  = (count_ff == '0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign accept   = req_push && !req_full;

   // Classify: drop pattern writes beyond the store, mark string terminators
   always_comb begin
      item.is_string = (req_opcode == OP_STRING_BYTE);
      item.is_end    = (req_byte_value == END_CHAR);
      item.index     = req_pattern_index;
      item.data      = req_byte_value;
      keep = item.is_string || (32'(req_pattern_index) < PATTERN_LEN);
   end

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && keep) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop && !q_empty) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if ((accept && keep) && !(q_pop && !q_empty)) begin
         count_in = count_ff + 1'b1;
      end else if (!(accept && keep) && (q_pop && !q_empty)) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold the queued words
   always_ff @(posedge clock) begin
      if (accept && keep) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

FILE: hw/rtl/wpm_back.sv
// Back end: sequencer that walks the pattern store for each queued word and
// holds the verdict register. Depends on wpm_pkg, wpm_ram and the defines header.
`include "wildcard_pattern_matcher_top_defines.svh"

module wpm_back import wpm_pkg::*; #(
   parameter int PATTERN_LEN = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fold_case,
   input  logic         q_empty,
   input  wpm_item_type q_item,
   output logic         q_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic         rsp_matched
);

   localparam int AW = $clog2(PATTERN_LEN);
   localparam int PW = $clog2(PATTERN_LEN + 1);
   localparam logic [PW-1:0] LAST_POS = PW'(PATTERN_LEN);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_SKIP,
      ST_END,
      ST_CMP
   } state_type;

   state_type      state_ff, state_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic [PW-1:0]  saved_ff, saved_in;
   logic           not_started_ff, not_started_in;
   logic           star_ff, star_in;
   logic           esc_ff, esc_in;
   logic           adv_ff, adv_in;
   logic           saved_valid_ff, saved_valid_in;
   logic           verdict_ff, verdict_in;
   logic           rsp_valid_ff;
   logic           rsp_matched_ff;

   logic [7:0]     rd_data;
   logic [7:0]     pat_b;
   logic [PW-1:0]  pos_next;
   logic [PW-1:0]  rd_pos;
   logic           ram_we;
   logic           chk_esc, chk_end, chk_cmp;
   logic           give_req, give_val, do_rearm, pop_req;
   logic           hit;
   logic           out_room, stall;

   wpm_ram #(
      .WIDTH (8),
      .DEPTH (PATTERN_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(q_item.index)),
      .wr_data (q_item.data),
      .rd_addr (rd_pos[AW-1:0]),
      .rd_data (rd_data)
   );

   // Positions past the store read as end of pattern
   assign pat_b    = (pos_ff >= LAST_POS) ? END_CHAR : rd_data;
   assign pos_next = (pos_ff >= LAST_POS) ? LAST_POS : pos_ff + 1'b1;
   assign out_room = !rsp_valid_ff || rsp_pop;

   // Per word: store a pattern write, drop words after a verdict, else advance, skip stars, escape, end check, compare
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      saved_in       = saved_ff;
      not_started_in = not_started_ff;
      star_in        = star_ff;
      esc_in         = esc_ff;
      adv_in         = adv_ff;
      saved_valid_in = saved_valid_ff;
      verdict_in     = verdict_ff;
      ram_we         = 1'b0;
      pop_req        = 1'b0;
      give_req       = 1'b0;
      give_val       = 1'b0;
      do_rearm       = 1'b0;
      chk_esc        = 1'b0;
      chk_end        = 1'b0;
      chk_cmp        = 1'b0;
      hit            = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (!q_item.is_string) begin
                  ram_we  = 1'b1;
                  pop_req = 1'b1;
               end else if (verdict_ff) begin
                  do_rearm = q_item.is_end;
                  pop_req  = 1'b1;
               end else if (adv_ff) begin
                  pos_in         = not_started_ff ? '0 : pos_next;
                  not_started_in = 1'b0;
                  adv_in         = 1'b0;
                  star_in        = 1'b0;
                  state_in       = ST_FIRST;
               end else begin
                  state_in = ST_CMP;
               end
            end
         end
         ST_FIRST: begin
            if (pat_b == STAR_CHAR) begin
               star_in  = 1'b1;
               pos_in   = pos_next;
               state_in = ST_SKIP;
            end else begin
               chk_esc = 1'b1;
            end
         end
         ST_SKIP: begin
            if (pat_b == STAR_CHAR) begin
               pos_in = pos_next;
            end else begin
               chk_esc = 1'b1;
            end
         end
         ST_END: begin
            chk_end = 1'b1;
         end
         ST_CMP: begin
            chk_cmp = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Escape: step over the backslash and compare the next byte literally
      if (chk_esc) begin
         if (pat_b == ESC_CHAR) begin
            pos_in   = pos_next;
            esc_in   = 1'b1;
            state_in = ST_END;
         end else begin
            esc_in  = 1'b0;
            chk_end = 1'b1;
         end
      end

      // End of pattern: match under a star or on terminator, else back up or fail
      if (chk_end) begin
         if (pat_b == END_CHAR) begin
            if (star_ff || q_item.is_end) begin
               give_req = 1'b1;
               give_val = 1'b1;
            end else if (!saved_valid_ff) begin
               give_req = 1'b1;
            end else begin
               star_in        = 1'b1;
               pos_in         = saved_ff;
               saved_valid_in = 1'b0;
               state_in       = ST_CMP;
            end
         end else begin
            chk_cmp = 1'b1;
         end
      end

      // Compare the string byte with the pattern byte
      if (chk_cmp) begin
         if (q_item.is_end) begin
            give_req = 1'b1;
         end else begin
            if (fold_case) begin
               hit = (fold_byte(q_item.data) == fold_byte(pat_b));
            end else begin
               hit = (q_item.data == pat_b);
            end
            if ((pat_b == ANY_CHAR) && !esc_in) begin
               hit = 1'b1;
            end
            pop_req  = 1'b1;
            state_in = ST_IDLE;
            if (hit && star_ff) begin
               saved_in       = pos_ff;
               saved_valid_in = 1'b1;
               star_in        = 1'b0;
               adv_in         = 1'b1;
            end else if (hit) begin
               adv_in = 1'b1;
            end else if (star_ff) begin
               adv_in = adv_ff;
            end else if (saved_valid_ff) begin
               star_in        = 1'b1;
               pos_in         = saved_ff;
               saved_valid_in = 1'b0;
            end else begin
               give_req = 1'b1;
            end
         end
      end

      // Verdict: drop the word, then re-arm on terminator or ignore the rest
      if (give_req) begin
         pop_req  = 1'b1;
         state_in = ST_IDLE;
         if (q_item.is_end) begin
            do_rearm = 1'b1;
         end else begin
            verdict_in = 1'b1;
         end
      end

      if (do_rearm) begin
         pos_in         = '0;
         not_started_in = 1'b1;
         star_in        = 1'b0;
         esc_in         = 1'b0;
         adv_in         = 1'b1;
         saved_in       = '0;
         saved_valid_in = 1'b0;
         verdict_in     = 1'b0;
      end
   end

   // Hold everything while a verdict waits for room
   assign stall  = give_req && !out_room;
   assign q_pop  = pop_req && !stall;
   assign rd_pos = stall ? pos_ff : pos_in;

   // Advance the sequencer and load the verdict word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pos_ff         <= '0;
         saved_ff       <= '0;
         not_started_ff <= 1'b1;
         star_ff        <= 1'b0;
         esc_ff         <= 1'b0;
         adv_ff         <= 1'b1;
         saved_valid_ff <= 1'b0;
         verdict_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_matched_ff <= 1'b0;
      end else begin
         if (!stall) begin
            state_ff       <= state_in;
            pos_ff         <= pos_in;
            saved_ff       <= saved_in;
            not_started_ff <= not_started_in;
            star_ff        <= star_in;
            esc_ff         <= esc_in;
            adv_ff         <= adv_in;
            saved_valid_ff <= saved_valid_in;
            verdict_ff     <= verdict_in;
         end
         if (give_req && out_room) begin
            rsp_valid_ff   <= 1'b1;
            rsp_matched_ff <= give_val;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_empty   = !rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

   `WPM_ASSERT_SAME(a_pos_bound, clock, reset, 1'b1, pos_ff <= LAST_POS, "position past store end")
   `WPM_ASSERT_SAME(a_fresh_string, clock, reset, not_started_ff, (pos_ff == '0) && !saved_valid_ff, "fresh string has state")
   `WPM_ASSERT_SAME(a_verdict_idle, clock, reset, verdict_ff, state_ff == ST_IDLE, "sequencer busy after verdict")
   `WPM_ASSERT_SAME(a_skip_star, clock, reset, state_ff == ST_SKIP, star_ff, "star skip without star")
   `WPM_ASSERT_NEXT(a_stall_hold, clock, reset, stall, $stable(pos_ff) && $stable(state_ff), "state moved during stall")

endmodule

FILE: hw/rtl/wildcard_pattern_matcher_top.sv
// Top level of the wildcard pattern matcher: front queue, back sequencer, CSR.
// Depends on wpm_pkg, wpm_front, wpm_back (and wpm_ram below it).
//
//   channel   ports                                         handshake
//   -------   -------------------------------------------   ---------------------
//   request   req_opcode, req_pattern_index, req_byte_value  req_push / req_full
//   response  rsp_matched                                    rsp_empty / rsp_pop
//   csr       csr_wdata (fold_case)                          csr_we
//
// Pattern writes and string bytes after a verdict are taken in the idle state;
// other string bytes take further steps, one more per star, escape or back-up
// at the pattern end, each step one registered read of the pattern RAM.
// Synchronous active-high reset; the pattern store is not cleared and must be
// written before use. The 2-word queue keeps taking words while a verdict waits;
// the sequencer stalls only while the response register is full.
module wildcard_pattern_matcher_top import wpm_pkg::*; #(
   parameter int PATTERN_LEN = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_opcode,
   input  logic [5:0] req_pattern_index,
   input  logic [7:0] req_byte_value,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_matched,
   input  logic       csr_we,
   input  logic       csr_wdata
);

   logic         fold_case_ff;
   logic         q_empty;
   logic         q_pop;
   wpm_item_type q_item;

   // Fold-case register, set after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         fold_case_ff <= 1'b1;
      end else if (csr_we) begin
         fold_case_ff <= csr_wdata;
      end
   end

   wpm_front #(
      .PATTERN_LEN (PATTERN_LEN)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_opcode        (req_opcode),
      .req_pattern_index (req_pattern_index),
      .req_byte_value    (req_byte_value),
      .q_empty           (q_empty),
      .q_item            (q_item),
      .q_pop             (q_pop)
   );

   wpm_back #(
      .PATTERN_LEN (PATTERN_LEN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .fold_case   (fold_case_ff),
      .q_empty     (q_empty),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_matched (rsp_matched)
   );

endmodule
